[rtl/dsa_pkg.sv]
// Types, opcodes and constants shared by the decimal scaled ALU files.
`default_nettype none
package dsa_pkg;

    typedef enum logic [2:0] {
        OP_ADD = 3'd0,
        OP_SUB = 3'd1,
        OP_MUL = 3'd2,
        OP_DIV = 3'd3,
        OP_REM = 3'd4,
        OP_AND = 3'd5,
        OP_OR  = 3'd6,
        OP_XOR = 3'd7
    } t_opcode;

    localparam logic [31:0] AUTO_A_LIMIT = 32'd4294;
    localparam logic [31:0] AUTO_B_LIMIT = 32'd4294967;
    localparam logic [31:0] AUTO_FACTOR  = 32'd1000;
    localparam logic [2:0]  AUTO_PLACES  = 3'd3;
    localparam int          DIV_BITS     = 32;

    typedef struct packed {
        t_opcode     opcode;
        logic [2:0]  places;
        logic        auto_div;
        logic        hex;
        logic        b_zero;
    } t_ctl;

    typedef struct packed {
        logic [31:0] num;
        logic [31:0] den;
        logic [31:0] rem;
    } t_div_lane;

    typedef struct packed {
        logic        valid;
        t_ctl        ctl;
        logic [31:0] lres;
        t_div_lane   main;
        t_div_lane   chk;
    } t_stage;

    function automatic logic [31:0] pow10(input logic [2:0] p);
        logic [31:0] e;
        case (p)
            3'd0:    e = 32'd1;
            3'd1:    e = 32'd10;
            3'd2:    e = 32'd100;
            3'd3:    e = 32'd1000;
            3'd4:    e = 32'd10000;
            3'd5:    e = 32'd100000;
            3'd6:    e = 32'd1000000;
            default: e = 32'd10000000;
        endcase
        return e;
    endfunction

    function automatic t_div_lane div_step(input t_div_lane d);
        t_div_lane   o;
        logic [32:0] t;
        logic [32:0] s;
        t = {d.rem, d.num[31]};
        s = t - {1'b0, d.den};
        o.den = d.den;
        if (!s[32]) begin
            o.rem = s[31:0];
            o.num = {d.num[30:0], 1'b1};
        end else begin
            o.rem = t[31:0];
            o.num = {d.num[30:0], 1'b0};
        end
        return o;
    endfunction

endpackage
`default_nettype wire

[rtl/dsa_if.sv]
// Request and result channel interfaces of the decimal scaled ALU.
`default_nettype none
interface dsa_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  opcode;
    logic [31:0] operand_a;
    logic [31:0] operand_b;
    logic [2:0]  decimal_places;
    logic        hex_mode;
    modport source(output valid, opcode, operand_a, operand_b, decimal_places, hex_mode,
                   input ready);
    modport sink(input valid, opcode, operand_a, operand_b, decimal_places, hex_mode,
                 output ready);
endinterface

interface dsa_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] result;
    logic [2:0]  decimal_places_out;
    logic        divide_by_zero;
    modport source(output valid, result, decimal_places_out, divide_by_zero, input ready);
    modport sink(input valid, result, decimal_places_out, divide_by_zero, output ready);
endinterface
`default_nettype wire

[rtl/decimal_scaled_alu_core.sv]
// Decimal scaled ALU: fully pipelined add, sub, mul, div, rem and logic ops.
//
// Requests arrive on i_req (valid/ready) carrying opcode, two 32-bit operands,
// a decimal-place count and a hex-mode flag. Each request yields exactly one
// result on o_rsp: a 32-bit result, the result's decimal places and a
// divide-by-zero flag. Results leave in request order.
//
// Throughput is one request per cycle while the output does not stall. The
// pipeline has one input stage, one stage for the 32x32 multiplier, 32
// restoring divide stages (one quotient bit each) and one output stage.
// Multiply by scale and divide by scale both run through the
// same multiplier and divider; a second divide lane alongside finds a mod b
// for the automatic three-place promotion.
//
// Reset clears every stage valid bit; no result is presented afterwards
// until a new request enters. When the receiver holds ready low with a
// result waiting, the whole pipeline holds and i_req.ready drops; nothing is
// lost or repeated. Bubbles inside the pipe advance while the output is free.
`default_nettype none
module decimal_scaled_alu_core
    import dsa_pkg::*;
#(
    parameter int MAX_DECIMALS = 4
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    dsa_in_if.sink    i_req,
    dsa_out_if.source o_rsp
);

    logic        en;
    logic        r_out_valid;
    logic [31:0] r_out_result;
    logic [2:0]  r_out_places;
    logic        r_out_dz;

    assign en          = !r_out_valid || o_rsp.ready;
    assign i_req.ready = en;

    // input stage
    logic [2:0]  n_places;
    logic        n_small;
    t_opcode     n_op;
    logic        r_s0_valid;
    t_ctl        r_s0_ctl;
    logic [31:0] r_s0_a;
    logic [31:0] r_s0_b;
    logic [31:0] r_s0_e;

    always_comb begin
        n_op = t_opcode'(i_req.opcode);
        if (32'(i_req.decimal_places) > 32'(MAX_DECIMALS)) begin
            n_places = 3'(MAX_DECIMALS);
        end else begin
            n_places = i_req.decimal_places;
        end
        n_small = (n_op == OP_DIV) && (n_places == 3'd0) && (i_req.operand_b != 32'd0)
                  && (i_req.operand_a < AUTO_A_LIMIT) && (i_req.operand_b < AUTO_B_LIMIT);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_valid <= 1'b0;
        end else if (en) begin
            r_s0_valid <= i_req.valid;
        end
        if (en) begin
            r_s0_ctl.opcode   <= n_op;
            r_s0_ctl.places   <= n_places;
            r_s0_ctl.auto_div <= n_small;
            r_s0_ctl.hex      <= i_req.hex_mode;
            r_s0_ctl.b_zero   <= (i_req.operand_b == 32'd0);
            r_s0_a            <= i_req.operand_a;
            r_s0_b            <= i_req.operand_b;
            r_s0_e            <= i_req.hex_mode ? 32'd1 : pow10(n_places);
        end
    end

    // multiply stage
    logic [31:0] n_y;
    logic [31:0] n_prod;
    logic [31:0] n_lres;
    t_stage      n_s1;

    always_comb begin
        case (r_s0_ctl.opcode)
            OP_MUL:  n_y = r_s0_b;
            OP_DIV:  n_y = (r_s0_ctl.auto_div && !r_s0_ctl.hex) ? AUTO_FACTOR : r_s0_e;
            default: n_y = 32'd1;
        endcase
        n_prod = r_s0_a * n_y;
        case (r_s0_ctl.opcode)
            OP_ADD:  n_lres = r_s0_a + r_s0_b;
            OP_SUB:  n_lres = r_s0_a - r_s0_b;
            OP_AND:  n_lres = r_s0_a & r_s0_b;
            OP_OR:   n_lres = r_s0_a | r_s0_b;
            default: n_lres = r_s0_a ^ r_s0_b;
        endcase
        n_s1.valid    = r_s0_valid;
        n_s1.ctl      = r_s0_ctl;
        n_s1.lres     = n_lres;
        n_s1.main.num = n_prod;
        n_s1.main.den = (r_s0_ctl.opcode == OP_MUL) ? r_s0_e : r_s0_b;
        n_s1.main.rem = 32'd0;
        n_s1.chk.num  = r_s0_a;
        n_s1.chk.den  = r_s0_b;
        n_s1.chk.rem  = 32'd0;
    end

    t_stage r_pipe [DIV_BITS+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pipe[0].valid <= 1'b0;
        end else if (en) begin
            r_pipe[0].valid <= n_s1.valid;
        end
        if (en) begin
            r_pipe[0].ctl  <= n_s1.ctl;
            r_pipe[0].lres <= n_s1.lres;
            r_pipe[0].main <= n_s1.main;
            r_pipe[0].chk  <= n_s1.chk;
        end
    end

    // divide stages, one quotient bit each
    for (genvar k = 0; k < DIV_BITS; k++) begin : g_div
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_pipe[k+1].valid <= 1'b0;
            end else if (en) begin
                r_pipe[k+1].valid <= r_pipe[k].valid;
            end
            if (en) begin
                r_pipe[k+1].ctl  <= r_pipe[k].ctl;
                r_pipe[k+1].lres <= r_pipe[k].lres;
                r_pipe[k+1].main <= div_step(r_pipe[k].main);
                r_pipe[k+1].chk  <= div_step(r_pipe[k].chk);
            end
        end
    end

    // result select
    t_stage      last;
    logic [31:0] n_result;
    logic [2:0]  n_places_out;
    logic        n_dz;
    logic        promote;

    always_comb begin
        last         = r_pipe[DIV_BITS];
        promote      = last.ctl.auto_div && (last.chk.rem != 32'd0);
        n_places_out = last.ctl.places;
        n_dz         = 1'b0;
        case (last.ctl.opcode)
            OP_MUL: begin
                n_result = last.main.num;
            end
            OP_DIV: begin
                if (last.ctl.b_zero) begin
                    n_result = 32'd0;
                    n_dz     = 1'b1;
                end else if (promote) begin
                    n_result     = last.main.num;
                    n_places_out = AUTO_PLACES;
                end else if (last.ctl.auto_div) begin
                    n_result = last.chk.num;
                end else begin
                    n_result = last.main.num;
                end
            end
            OP_REM: begin
                if (last.ctl.b_zero) begin
                    n_result = 32'd0;
                    n_dz     = 1'b1;
                end else begin
                    n_result = last.main.rem;
                end
            end
            default: begin
                n_result = last.lres;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= last.valid;
        end
        if (en) begin
            r_out_result <= n_result;
            r_out_places <= n_places_out;
            r_out_dz     <= n_dz;
        end
    end

    assign o_rsp.valid              = r_out_valid;
    assign o_rsp.result             = r_out_result;
    assign o_rsp.decimal_places_out = r_out_places;
    assign o_rsp.divide_by_zero     = r_out_dz;

endmodule
`default_nettype wire

[dv/testbench.sv]
// Testbench for the decimal scaled ALU: random and directed requests checked against a predictor.
`timescale 1ns / 100ps
`default_nettype none
module testbench;
    import dsa_pkg::*;

    typedef struct {
        logic [31:0] result;
        logic [2:0]  places;
        logic        dz;
    } t_expect;

    class alu_scoreboard;
        t_expect pending[$];
        int      errors;

        function void note_request(t_opcode op, logic [31:0] a, logic [31:0] b,
                                   logic [2:0] pl, logic hx);
            t_expect     x;
            logic [31:0] sc;
            logic [63:0] p;
            logic [2:0]  dp;
            dp = (pl > 3'd4) ? 3'd4 : pl;
            x.dz = 1'b0;
            x.result = '0;
            if (op == OP_DIV && dp == 3'd0 && b != 0 && (a % b) != 0
                && a < 32'd4294 && b < 32'd4294967) begin
                a = a * 32'd1000;
                b = b * 32'd1000;
                dp = 3'd3;
            end
            sc = 1;
            if (!hx) for (int i = 0; i < dp; i++) sc = sc * 10;
            case (op)
                OP_ADD: x.result = a + b;
                OP_SUB: x.result = a - b;
                OP_MUL: begin
                    p = a * b;
                    x.result = p[31:0] / sc;
                end
                OP_DIV: begin
                    if (b == 0) x.dz = 1'b1;
                    else begin
                        p = a * sc;
                        x.result = p[31:0] / b;
                    end
                end
                OP_REM: begin
                    if (b == 0) x.dz = 1'b1;
                    else x.result = a % b;
                end
                OP_AND: x.result = a & b;
                OP_OR:  x.result = a | b;
                default: x.result = a ^ b;
            endcase
            x.places = dp;
            pending.push_back(x);
        endfunction

        function void check_result(logic [31:0] r, logic [2:0] pl, logic dz);
            t_expect x;
            if (pending.size() == 0) begin
                $display("%0t unexpected result %h", $time, r);
                errors++;
                return;
            end
            x = pending.pop_front();
            if (r !== x.result || pl !== x.places || dz !== x.dz) begin
                $display("%0t mismatch exp %h/%0d/%b act %h/%0d/%b", $time,
                         x.result, x.places, x.dz, r, pl, dz);
                errors++;
            end
        endfunction
    endclass

    logic i_clk = 0;
    logic i_rst_n = 0;
    dsa_in_if  req_if();
    dsa_out_if rsp_if();
    alu_scoreboard sb = new();
    bit calm = 0;

    decimal_scaled_alu_core dut (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(req_if.sink),
                                 .o_rsp(rsp_if.source));

    always #4 i_clk = ~i_clk;

    initial begin
        req_if.valid = 0;
        req_if.opcode = 0;
        req_if.operand_a = 0;
        req_if.operand_b = 0;
        req_if.decimal_places = 0;
        req_if.hex_mode = 0;
        rsp_if.ready = 0;
    end

    always @(posedge i_clk)
        if (i_rst_n && rsp_if.valid && rsp_if.ready)
            sb.check_result(rsp_if.result, rsp_if.decimal_places_out, rsp_if.divide_by_zero);

    always @(negedge i_clk)
        rsp_if.ready <= calm || ($urandom_range(99) >= 6);

    task automatic send_request(logic [2:0] op, logic [31:0] a, logic [31:0] b,
                                logic [2:0] pl, logic hx);
        while (!calm && $urandom_range(99) < 6) begin
            req_if.valid <= 0;
            @(negedge i_clk);
        end
        req_if.valid <= 1;
        req_if.opcode <= op;
        req_if.operand_a <= a;
        req_if.operand_b <= b;
        req_if.decimal_places <= pl;
        req_if.hex_mode <= hx;
        do @(posedge i_clk); while (!req_if.ready);
        sb.note_request(t_opcode'(op), a, b, pl, hx);
        @(negedge i_clk);
    endtask

    function automatic logic [31:0] pick_operand();
        case ($urandom_range(5))
            0: return $urandom_range(4300);
            1: return $urandom_range(4294970);
            2: return 32'hFFFF_FFFF - $urandom_range(3);
            default: return $urandom;
        endcase
    endfunction

    initial begin
        logic [31:0] a;
        logic [31:0] b;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1;
        for (int op = 0; op < 8; op++) begin
            send_request(3'(op), 32'hFFFF_FFFF, 32'hFFFF_FFFF, 3'd7, 1'b0);
            send_request(3'(op), 32'd0, 32'd0, 3'd0, 1'b1);
        end
        send_request(OP_DIV, 32'd10, 32'd3, 3'd0, 1'b0);
        send_request(OP_DIV, 32'd10, 32'd3, 3'd0, 1'b1);
        send_request(OP_DIV, 32'd4293, 32'd4294966, 3'd0, 1'b0);
        send_request(OP_DIV, 32'd4294, 32'd7, 3'd0, 1'b0);
        send_request(OP_DIV, 32'd9, 32'd3, 3'd0, 1'b0);
        send_request(OP_MUL, 32'd12345, 32'd6789, 3'd2, 1'b0);
        send_request(OP_DIV, 32'd12345, 32'd67, 3'd4, 1'b0);
        send_request(OP_REM, 32'd100, 32'd0, 3'd5, 1'b0);
        for (int n = 0; n < 1900; n++) begin
            calm = (n >= 800 && n < 1100);
            a = pick_operand();
            b = ($urandom_range(19) == 0) ? 32'd0 : pick_operand();
            send_request(3'($urandom_range(7)), a, b, 3'($urandom_range(7)),
                         1'($urandom_range(1)));
        end
        req_if.valid <= 0;
        calm = 0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (sb.errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        #2000000;
        $display("RESULT: ERROR");
        $finish;
    end
endmodule
`default_nettype wire

[files.f]
rtl/dsa_pkg.sv
rtl/dsa_if.sv
rtl/decimal_scaled_alu_core.sv
dv/testbench.sv
